[hw/rtl/bst_pkg.sv]
// Shared types and constants for the bitmap slot table.
`timescale 1ns / 1ps

package bst_pkg;

  localparam int KEY_W   = 64;
  localparam int SLOT_W  = 6;
  localparam int CNT_W   = 7;
  localparam int STAT_W  = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] entry_key;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_index;
    logic [CNT_W-1:0]  live_count;
  } out_t;

  typedef enum logic [1:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_SCAN
  } ctrl_state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic scan_adv;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_end;
  } dp_sts_t;

endpackage

[hw/rtl/bitmap_slot_table_add_delete_unit.sv]
// Top level of the bitmap slot table with add and delete requests.
`timescale 1ns / 1ps

// Channel   Direction  Payload  Handshake
// in_       input      in_t     in_valid / in_ready
// out_      output     out_t    out_valid / out_ready
//
// A request scans the slot memory from slot 0 in order, one slot per cycle, and
// stops at the first slot that serves it or at the last slot.
// After reset a clearing pass writes every slot before in_ready rises.
// A result waiting on out_ready lets the next request be taken and scanned;
// that scan holds at its final slot until the output register is free.

module bitmap_slot_table_add_delete_unit
  import bst_pkg::*;
#(
  parameter int SLOT_COUNT = 64,
  parameter int KEY_BITS   = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  bst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bst_datapath #(
    .SLOT_COUNT (SLOT_COUNT),
    .KEY_BITS   (KEY_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

[hw/rtl/bst_ctrl.sv]
// Controller state machine for the bitmap slot table.
`timescale 1ns / 1ps

module bst_ctrl
  import bst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_free      = !out_valid_r || out_ready;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      CS_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = CS_IDLE;
        end
      end
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = CS_SCAN;
        end
      end
      CS_SCAN: begin
        if (sts.scan_end) begin
          if (out_free) begin
            cmd.finish    = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = CS_IDLE;
          end
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      default: begin
        state_nxt = CS_CLEAR;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[hw/rtl/bst_datapath.sv]
// Datapath for the bitmap slot table: slot memory, scan pipeline, counts and result.
`timescale 1ns / 1ps

module bst_datapath
  import bst_pkg::*;
#(
  parameter int SLOT_COUNT = 64,
  parameter int KEY_BITS   = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_t       in_data,
  input  ctrl_cmd_t cmd,
  output dp_sts_t   sts,
  output out_t      out_data
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

  logic [KEY_BITS:0]   mem [SLOT_COUNT];
  logic [KEY_BITS:0]   rd_data_r;
  logic                mem_we;
  logic [IW-1:0]       mem_wa;
  logic [KEY_BITS:0]   mem_wd;

  logic [IW-1:0]       issue_idx_r, issue_idx_nxt;
  logic [IW-1:0]       chk_idx_r;
  logic                chk_valid_r, chk_valid_nxt;
  logic                op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [CNT_W-1:0]    occ_r, occ_nxt;
  logic [CNT_W-1:0]    freed_r, freed_nxt;
  out_t                res_r;

  logic                rd_occ;
  logic [KEY_BITS-1:0] rd_key;
  logic                hit;
  logic                commit;
  logic [SLOT_W+IW-1:0] slot_ext;

  assign rd_occ = rd_data_r[KEY_BITS];
  assign rd_key = rd_data_r[KEY_BITS-1:0];
  assign hit    = chk_valid_r &&
                  ((op_r == OP_ADD) ? !rd_occ : (rd_occ && (rd_key == key_r)));
  assign commit = cmd.finish && hit;

  assign sts.scan_end   = chk_valid_r && (hit || (chk_idx_r == LAST_IDX));
  assign sts.clear_last = (issue_idx_r == LAST_IDX);

  assign mem_we = cmd.clear || commit;
  assign mem_wa = cmd.clear ? issue_idx_r : chk_idx_r;
  assign mem_wd = cmd.clear ? '0 : {(op_r == OP_ADD), key_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.scan_adv) begin
      rd_data_r <= mem[issue_idx_r];
    end
  end

  always_comb begin
    issue_idx_nxt = issue_idx_r;
    chk_valid_nxt = chk_valid_r;
    if (cmd.load) begin
      issue_idx_nxt = '0;
      chk_valid_nxt = 1'b0;
    end else if (cmd.clear) begin
      issue_idx_nxt = (issue_idx_r == LAST_IDX) ? '0 : IW'(issue_idx_r + 1'b1);
    end else if (cmd.scan_adv) begin
      chk_valid_nxt = 1'b1;
      if (issue_idx_r != LAST_IDX) begin
        issue_idx_nxt = IW'(issue_idx_r + 1'b1);
      end
    end
  end

  always_comb begin
    occ_nxt   = occ_r;
    freed_nxt = freed_r;
    if (commit) begin
      if (op_r == OP_ADD) begin
        occ_nxt   = (occ_r < CNT_MAX) ? CNT_W'(occ_r + 1'b1) : CNT_MAX;
        freed_nxt = (freed_r != '0) ? CNT_W'(freed_r - 1'b1) : '0;
      end else begin
        occ_nxt   = (occ_r != '0) ? CNT_W'(occ_r - 1'b1) : '0;
        freed_nxt = (freed_r < CNT_MAX) ? CNT_W'(freed_r + 1'b1) : CNT_MAX;
      end
    end
  end

  assign slot_ext = {{SLOT_W{1'b0}}, chk_idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_idx_r <= '0;
      chk_valid_r <= 1'b0;
      occ_r       <= '0;
      freed_r     <= '0;
    end else begin
      issue_idx_r <= issue_idx_nxt;
      chk_valid_r <= chk_valid_nxt;
      occ_r       <= occ_nxt;
      freed_r     <= freed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_data.operation;
      key_r <= in_data.entry_key[KEY_BITS-1:0];
    end
    if (cmd.scan_adv) begin
      chk_idx_r <= issue_idx_r;
    end
    if (cmd.finish) begin
      res_r.live_count <= occ_nxt;
      if (hit) begin
        res_r.status     <= STAT_OK;
        res_r.slot_index <= slot_ext[SLOT_W-1:0];
      end else begin
        res_r.status     <= (op_r == OP_ADD) ? STAT_FULL : STAT_NOT_FOUND;
        res_r.slot_index <= '0;
      end
    end
  end

  assign out_data = res_r;

  a_del_lowers_count: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (op_r == OP_DELETE) && (occ_r != '0)) |=> (occ_r == $past(occ_r) - 1'b1))
    else $error("delete did not lower the live count");

  a_add_raises_count: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (op_r == OP_ADD) && (occ_r != CNT_MAX)) |=> (occ_r == $past(occ_r) + 1'b1))
    else $error("add did not raise the live count");

  a_miss_keeps_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && !hit) |=> ($stable(occ_r) && $stable(freed_r)))
    else $error("failed request changed the counts");

  a_full_only_on_add: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && !hit && (op_r == OP_ADD)) |=> (res_r.status == STAT_FULL))
    else $error("failed add did not report full");

endmodule

[test/bitmap_slot_table_add_delete_unit_tb.sv]
// Self-checking testbench for the bitmap slot table add/delete unit.
`timescale 1ns / 1ps

module bitmap_slot_table_add_delete_unit_tb;
  import bst_pkg::*;

  localparam int SLOTS     = 64;
  localparam int KEY_USED  = 64;
  localparam int RAND_ITEMS = 1700;
  localparam int POOL_SIZE  = 24;
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_USED);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  in_t  request_queue[$];
  out_t expected_results[$];
  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  logic             slot_used[SLOTS];
  logic [KEY_W-1:0] slot_key[SLOTS];
  logic [CNT_W-1:0] live_total;
  logic [CNT_W-1:0] freed_total;

  int request_total;
  int requests_sent;
  int mismatch_count;
  int in_gap;
  int out_stall;
  bit in_calm;
  bit out_calm;

  bitmap_slot_table_add_delete_unit #(
    .SLOT_COUNT(SLOTS),
    .KEY_BITS(KEY_USED)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void apply_table_request(in_t req);
    out_t res;
    logic [KEY_W-1:0] key;
    int hit_slot;
    key = req.entry_key & KEY_MASK;
    hit_slot = -1;
    res.status = (req.operation == OP_ADD) ? STAT_FULL : STAT_NOT_FOUND;
    res.slot_index = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (req.operation == OP_ADD ? !slot_used[i]
                                  : (slot_used[i] && slot_key[i] == key)) begin
        hit_slot = i;
        break;
      end
    end
    if (hit_slot >= 0) begin
      res.status = STAT_OK;
      res.slot_index = hit_slot[SLOT_W-1:0];
      if (req.operation == OP_ADD) begin
        slot_used[hit_slot] = 1'b1;
        slot_key[hit_slot] = key;
        if (live_total != CNT_MAX) live_total = live_total + 1'b1;
        if (freed_total != '0) freed_total = freed_total - 1'b1;
      end else begin
        slot_used[hit_slot] = 1'b0;
        if (live_total != '0) live_total = live_total - 1'b1;
        if (freed_total != CNT_MAX) freed_total = freed_total + 1'b1;
      end
    end
    res.live_count = live_total;
    expected_results.push_back(res);
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  function automatic in_t make_request(logic op, logic [KEY_W-1:0] key);
    in_t req;
    req.operation = op;
    req.entry_key = key;
    return req;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_table_request(in_data);
        requests_sent <= requests_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (request_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= request_queue.pop_front();
          if ($urandom_range(0, 99) < 2) in_calm = !in_calm;
          in_gap <= pick_gap(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d slot=%0d live=%0d", $time,
                   out_data.status, out_data.slot_index, out_data.live_count);
          mismatch_count++;
        end else begin
          out_t exp_res;
          exp_res = expected_results.pop_front();
          if (out_data.status !== exp_res.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_res.status, out_data.status);
            mismatch_count++;
          end
          if (out_data.slot_index !== exp_res.slot_index) begin
            $display("%0t: slot_index expected %0d actual %0d", $time,
                     exp_res.slot_index, out_data.slot_index);
            mismatch_count++;
          end
          if (out_data.live_count !== exp_res.live_count) begin
            $display("%0t: live_count expected %0d actual %0d", $time,
                     exp_res.live_count, out_data.live_count);
            mismatch_count++;
          end
        end
        if ($urandom_range(0, 99) < 2) out_calm = !out_calm;
      end
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else if (!out_calm && $urandom_range(0, 99) < 25) begin
        out_ready <= 1'b0;
        out_stall <= pick_gap(1'b0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int produced;
    int phase_left;
    int add_percent;
    bit filling;
    logic op;
    logic [KEY_W-1:0] key;

    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i] = '0;
    end
    live_total = '0;
    freed_total = '0;
    requests_sent = 0;
    mismatch_count = 0;
    in_calm = 1'b0;
    out_calm = 1'b0;

    // Duplicates, holes, misses on stale keys and an empty table.
    request_queue.push_back(make_request(OP_ADD, '0));
    request_queue.push_back(make_request(OP_ADD, '1));
    request_queue.push_back(make_request(OP_ADD, 64'h5555_5555_5555_5555));
    request_queue.push_back(make_request(OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA));
    request_queue.push_back(make_request(OP_ADD, '1));
    request_queue.push_back(make_request(OP_DELETE, 64'h0000_0000_0000_1234));
    request_queue.push_back(make_request(OP_DELETE, '1));
    request_queue.push_back(make_request(OP_DELETE, '1));
    request_queue.push_back(make_request(OP_DELETE, '1));
    request_queue.push_back(make_request(OP_ADD, 64'h8000_0000_0000_0001));
    request_queue.push_back(make_request(OP_DELETE, '0));
    request_queue.push_back(make_request(OP_DELETE, '0));
    request_queue.push_back(make_request(OP_DELETE, 64'h5555_5555_5555_5555));
    request_queue.push_back(make_request(OP_DELETE, 64'hAAAA_AAAA_AAAA_AAAA));
    request_queue.push_back(make_request(OP_DELETE, 64'h8000_0000_0000_0001));
    request_queue.push_back(make_request(OP_DELETE, 64'h8000_0000_0000_0001));
    request_queue.push_back(make_request(OP_ADD, 64'h0000_0000_0000_0001));
    request_queue.push_back(make_request(OP_DELETE, 64'h0000_0000_0000_0001));
    request_queue.push_back(make_request(OP_DELETE, '1));

    // The table alternates between fill phases that mostly add and drain
    // phases that mostly delete, with keys mostly drawn from a small pool.
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = random_key();
    produced = 0;
    phase_left = 0;
    filling = 1'b0;
    add_percent = 50;
    while (produced < RAND_ITEMS) begin
      if (phase_left == 0) begin
        filling = !filling;
        phase_left = $urandom_range(80, 200);
        add_percent = filling ? $urandom_range(75, 92) : $urandom_range(10, 30);
      end
      op = ($urandom_range(0, 99) < add_percent) ? OP_ADD : OP_DELETE;
      if ($urandom_range(0, 99) < 82)
        key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else
        key = random_key();
      request_queue.push_back(make_request(op, key));
      produced++;
      phase_left--;
    end
    request_total = request_queue.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (!(requests_sent == request_total && expected_results.size() == 0))
      @(posedge clk);
    repeat (150) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("bitmap_slot_table_add_delete_unit test passed");
    end else begin
      $display("bitmap_slot_table_add_delete_unit test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("bitmap_slot_table_add_delete_unit test failed");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/bst_pkg.sv
hw/rtl/bst_ctrl.sv
hw/rtl/bst_datapath.sv
hw/rtl/bitmap_slot_table_add_delete_unit.sv
test/bitmap_slot_table_add_delete_unit_tb.sv
